// File: hdl/pidaw_pkg.sv
// Shared types, constants and the microcode program of the PID controller.
// No dependencies; imported by every module of the block.
package pidaw_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int VAL_W     = 32;
   localparam int PERIOD_W  = 31;
   localparam int OPND_W    = VAL_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int STEP_W    = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [VAL_W-1:0]  KP_RST        = 32'sd65536;
   localparam logic signed [VAL_W-1:0]  KI_RST        = 32'sd0;
   localparam logic signed [VAL_W-1:0]  KD_RST        = 32'sd0;
   localparam logic [PERIOD_W-1:0]      PERIOD_RST    = 31'd655;
   localparam logic signed [VAL_W-1:0]  OUT_MIN_RST   = -32'sd6553600;
   localparam logic signed [VAL_W-1:0]  OUT_MAX_RST   = 32'sd6553600;
   localparam logic [PERIOD_W-1:0]      INT_LIMIT_RST = 31'd3276800;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP, CSR_KI, CSR_KD, CSR_PERIOD, CSR_OUT_MIN, CSR_OUT_MAX, CSR_INT_LIMIT
   } csr_idx_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_ERR_DT, MUL_KP_ERR, MUL_KI_INT, MUL_KD_DIFF
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD_INT, ACC_LOAD_PROD, ACC_ADD_PROD
   } acc_op_type;

   typedef struct packed {
      logic              err_we;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              int_we;
      logic              out_we;
      logic              clr_we;
      logic              br_clear;
      logic [STEP_W-1:0] target;
      logic              last;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      fire;
   } ctl_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] kp;
      logic signed [VAL_W-1:0] ki;
      logic signed [VAL_W-1:0] kd;
      logic [PERIOD_W-1:0]     period;
      logic signed [VAL_W-1:0] out_min;
      logic signed [VAL_W-1:0] out_max;
      logic [PERIOD_W-1:0]     int_limit;
   } cfg_type;

   localparam logic [STEP_W-1:0] ST_ERR     = 4'd0;
   localparam logic [STEP_W-1:0] ST_MUL_DT  = 4'd1;
   localparam logic [STEP_W-1:0] ST_INT_SUM = 4'd2;
   localparam logic [STEP_W-1:0] ST_INT_CLP = 4'd3;
   localparam logic [STEP_W-1:0] ST_MUL_KI  = 4'd4;
   localparam logic [STEP_W-1:0] ST_MUL_KD  = 4'd5;
   localparam logic [STEP_W-1:0] ST_ADD_D   = 4'd6;
   localparam logic [STEP_W-1:0] ST_OUT     = 4'd7;
   localparam logic [STEP_W-1:0] ST_CLEAR   = 4'd8;

   function automatic ucode_type pidaw_ucode(input logic [STEP_W-1:0] step);
      ucode_type uw;
      uw = '0;
      uw.mul_sel = MUL_NONE;
      uw.acc_op  = ACC_HOLD;
      unique case (step)
         ST_ERR: begin
            uw.err_we   = 1'b1;
            uw.br_clear = 1'b1;
            uw.target   = ST_CLEAR;
         end
         ST_MUL_DT: begin
            uw.mul_sel = MUL_ERR_DT;
         end
         ST_INT_SUM: begin
            uw.acc_op  = ACC_LOAD_INT;
            uw.mul_sel = MUL_KP_ERR;
         end
         ST_INT_CLP: begin
            uw.int_we = 1'b1;
            uw.acc_op = ACC_LOAD_PROD;
         end
         ST_MUL_KI: begin
            uw.mul_sel = MUL_KI_INT;
         end
         ST_MUL_KD: begin
            uw.mul_sel = MUL_KD_DIFF;
            uw.acc_op  = ACC_ADD_PROD;
         end
         ST_ADD_D: begin
            uw.acc_op = ACC_ADD_PROD;
         end
         ST_OUT: begin
            uw.out_we = 1'b1;
            uw.last   = 1'b1;
         end
         ST_CLEAR: begin
            uw.clr_we = 1'b1;
            uw.last   = 1'b1;
         end
         default: begin
            uw.last = 1'b1;
         end
      endcase
      return uw;
   endfunction

endpackage

// File: hdl/pidaw_sequencer.sv
// Microcode sequencer: step counter, program ROM lookup and branch logic.
// Depends on pidaw_pkg.
module pidaw_sequencer
   import pidaw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    is_clear,
   input  logic    out_hold,
   output logic    busy,
   output ctl_type ctl
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   ucode_type         word;
   logic              advance;

   assign word    = pidaw_ucode(step_ff);
   assign advance = busy_ff & ~(word.out_we & out_hold);

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      priority if (start) begin
         step_in = ST_ERR;
         busy_in = 1'b1;
      end else if (advance) begin
         priority if (word.last) begin
            busy_in = 1'b0;
         end else if (word.br_clear & is_clear) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_ERR;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign ctl.word = word;
   assign ctl.fire = advance;

endmodule

// File: hdl/pidaw_datapath.sv
// PID datapath: error saturation, one shared multiplier, accumulator, clamps and state.
// Depends on pidaw_pkg; driven by pidaw_sequencer control words.
module pidaw_datapath
   import pidaw_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    in_clear,
   input  logic signed [VAL_W-1:0] in_setpoint,
   input  logic signed [VAL_W-1:0] in_measured,
   input  cfg_type                 cfg,
   input  ctl_type                 ctl,
   output logic                    is_clear,
   output logic signed [VAL_W-1:0] drive
);

   localparam int ERR_BITS = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
   localparam logic signed [OPND_W-1:0] ERR_HI =
      (33'sd1 <<< (ERR_BITS - 1)) - 33'sd1;
   localparam logic signed [OPND_W-1:0] ERR_LO = -ERR_HI - 33'sd1;

   logic                     clear_ff;
   logic signed [VAL_W-1:0]  setp_ff, meas_ff;
   logic signed [VAL_W-1:0]  err_ff, err_in;
   logic signed [VAL_W-1:0]  integ_ff, integ_in;
   logic signed [VAL_W-1:0]  last_ff, last_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [VAL_W-1:0]  drive_ff, drive_in;

   logic signed [OPND_W-1:0] diff, dterm, mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [ACC_W-1:0]  sh_ext, lim_hi, lim_lo, omin, omax;
   logic signed [VAL_W-1:0]  int_clamped, out_clamped;

   always_ff @(posedge clock) begin
      if (load) begin
         clear_ff <= in_clear;
         setp_ff  <= in_setpoint;
         meas_ff  <= in_measured;
      end
   end

   assign diff = {setp_ff[VAL_W-1], setp_ff} - {meas_ff[VAL_W-1], meas_ff};

   always_comb begin
      priority if (diff > ERR_HI) begin
         err_in = ERR_HI[VAL_W-1:0];
      end else if (diff < ERR_LO) begin
         err_in = ERR_LO[VAL_W-1:0];
      end else begin
         err_in = diff[VAL_W-1:0];
      end
   end

   assign dterm = {err_ff[VAL_W-1], err_ff} - {last_ff[VAL_W-1], last_ff};

   always_comb begin
      unique case (ctl.word.mul_sel)
         MUL_ERR_DT: begin
            mul_a = {err_ff[VAL_W-1], err_ff};
            mul_b = {2'b00, cfg.period};
         end
         MUL_KP_ERR: begin
            mul_a = {cfg.kp[VAL_W-1], cfg.kp};
            mul_b = {err_ff[VAL_W-1], err_ff};
         end
         MUL_KI_INT: begin
            mul_a = {cfg.ki[VAL_W-1], cfg.ki};
            mul_b = {integ_ff[VAL_W-1], integ_ff};
         end
         MUL_KD_DIFF: begin
            mul_a = {cfg.kd[VAL_W-1], cfg.kd};
            mul_b = dterm;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign sh_ext  = {{(ACC_W-PROD_W){prod_sh[PROD_W-1]}}, prod_sh};

   always_comb begin
      unique case (ctl.word.acc_op)
         ACC_LOAD_INT:  acc_in = {{(ACC_W-VAL_W){integ_ff[VAL_W-1]}}, integ_ff} + sh_ext;
         ACC_LOAD_PROD: acc_in = sh_ext;
         ACC_ADD_PROD:  acc_in = acc_ff + sh_ext;
         default:       acc_in = acc_ff;
      endcase
   end

   // integral clamp to +/- limit
   assign lim_hi = {{(ACC_W-PERIOD_W){1'b0}}, cfg.int_limit};
   assign lim_lo = -lim_hi;

   always_comb begin
      priority if (acc_ff > lim_hi) begin
         int_clamped = lim_hi[VAL_W-1:0];
      end else if (acc_ff < lim_lo) begin
         int_clamped = lim_lo[VAL_W-1:0];
      end else begin
         int_clamped = acc_ff[VAL_W-1:0];
      end
   end

   // output clamp; above out_max wins when the limits cross
   assign omax = {{(ACC_W-VAL_W){cfg.out_max[VAL_W-1]}}, cfg.out_max};
   assign omin = {{(ACC_W-VAL_W){cfg.out_min[VAL_W-1]}}, cfg.out_min};

   always_comb begin
      priority if (acc_ff > omax) begin
         out_clamped = cfg.out_max;
      end else if (acc_ff < omin) begin
         out_clamped = cfg.out_min;
      end else begin
         out_clamped = acc_ff[VAL_W-1:0];
      end
   end

   always_comb begin
      integ_in = integ_ff;
      last_in  = last_ff;
      drive_in = drive_ff;
      if (ctl.fire) begin
         if (ctl.word.int_we) begin
            integ_in = int_clamped;
         end
         if (ctl.word.out_we) begin
            drive_in = out_clamped;
            last_in  = err_ff;
         end
         if (ctl.word.clr_we) begin
            integ_in = '0;
            last_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else begin
         integ_ff <= integ_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_ff <= drive_in;
      if (ctl.fire && ctl.word.err_we) begin
         err_ff <= err_in;
      end
      if (ctl.fire && ctl.word.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (ctl.fire) begin
         acc_ff <= acc_in;
      end
   end

   assign is_clear = clear_ff;
   assign drive    = drive_ff;

endmodule

// File: hdl/pid_controller_anti_windup.sv
// PID controller with integral clamp, signed Q16.16 fixed point.
// Request channel: req_valid/req_stall carry req_type (0 compute, 1 clear),
//   req_setpoint and req_measured. req_stall is high while a request is in work.
// Response channel: rsp_valid/rsp_stall carry rsp_drive, one response per
//   compute request and none for a clear request.
// Config: csr_write_en, csr_index, csr_wdata write gains, sample period, output
//   limits and integral limit; write only while the block is idle.
// Sequencing: a compute request runs an 8-step microprogram on one shared
//   multiplier; rsp_valid rises once its last step writes the output register,
//   and the next request can be taken only after that last step has run.
//   A clear request runs 2 steps; no request is taken while one is in work.
// A finished response waits in its output register; the next request is
//   accepted meanwhile, and its final step holds while rsp_stall keeps the
//   previous response in place.
// Reset: synchronous, active high; clears integral, previous error, rsp_valid and the
//   sequencer and restores the config registers to their defaults; other data registers are not reset.
// Depends on pidaw_pkg, pidaw_sequencer, pidaw_datapath.
module pid_controller_anti_windup
   import pidaw_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic signed [VAL_W-1:0]     req_setpoint,
   input  logic signed [VAL_W-1:0]     req_measured,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [VAL_W-1:0]     rsp_drive,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [VAL_W-1:0]            csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    busy, accept, is_clear, out_hold;
   ctl_type ctl;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KP:        cfg_in.kp        = csr_wdata;
            CSR_KI:        cfg_in.ki        = csr_wdata;
            CSR_KD:        cfg_in.kd        = csr_wdata;
            CSR_PERIOD:    cfg_in.period    = csr_wdata[PERIOD_W-1:0];
            CSR_OUT_MIN:   cfg_in.out_min   = csr_wdata;
            CSR_OUT_MAX:   cfg_in.out_max   = csr_wdata;
            CSR_INT_LIMIT: cfg_in.int_limit = csr_wdata[PERIOD_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp        <= KP_RST;
         cfg_ff.ki        <= KI_RST;
         cfg_ff.kd        <= KD_RST;
         cfg_ff.period    <= PERIOD_RST;
         cfg_ff.out_min   <= OUT_MIN_RST;
         cfg_ff.out_max   <= OUT_MAX_RST;
         cfg_ff.int_limit <= INT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid & ~busy;
   assign out_hold  = rsp_valid_ff & rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (ctl.fire && ctl.word.out_we) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   pidaw_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .is_clear (is_clear),
      .out_hold (out_hold),
      .busy     (busy),
      .ctl      (ctl)
   );

   pidaw_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .in_clear    (req_type),
      .in_setpoint (req_setpoint),
      .in_measured (req_measured),
      .cfg         (cfg_ff),
      .ctl         (ctl),
      .is_clear    (is_clear),
      .drive       (rsp_drive)
   );

endmodule

// File: bench/testbench.sv
// Self-checking bench for pid_controller_anti_windup: directed corner cases, then random
// phases with random gains and limits. An internal Q16.16 predictor checks every drive.
// Depends on pidaw_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;
   import pidaw_pkg::*;

   localparam int WIDE          = 96;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 4000;
   localparam int NUM_CSR       = 7;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 200;

   localparam logic                    REQ_COMPUTE = 1'b0;
   localparam logic                    REQ_CLEAR   = 1'b1;
   localparam logic [CSR_IDX_W-1:0]    CSR_UNUSED  = 3'd7;
   localparam logic signed [VAL_W-1:0] VMAX        = 32'sh7fffffff;
   localparam logic signed [VAL_W-1:0] VMIN        = 32'sh80000000;
   localparam logic [PERIOD_W-1:0]     PMAX        = 31'h7fffffff;
   localparam logic signed [VAL_W-1:0] ONE         = 32'sd65536;

   logic                     clock;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic                     req_type     = REQ_COMPUTE;
   logic signed [VAL_W-1:0]  req_setpoint = '0;
   logic signed [VAL_W-1:0]  req_measured = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic signed [VAL_W-1:0]  rsp_drive;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index    = '0;
   logic [VAL_W-1:0]         csr_wdata    = '0;

   cfg_type                  gains;
   logic signed [VAL_W-1:0]  integ_state;
   logic signed [VAL_W-1:0]  last_err;
   logic signed [VAL_W-1:0]  drive_q [$];
   logic                     pace = 1'b0;
   int                       mismatches = 0;
   int                       quiet = 0;

   pid_controller_anti_windup u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // one control step; products floor-shifted, sum kept exact
   function automatic logic signed [VAL_W-1:0] pid_step(input logic signed [VAL_W-1:0] sp,
                                                        input logic signed [VAL_W-1:0] ms);
      logic signed [WIDE-1:0] err, dt, lim, acc, k, p, i, d, sum, lo, hi;
      err = sp;
      err = err - ms;
      if (err > VMAX) err = VMAX;
      else if (err < VMIN) err = VMIN;
      dt  = $signed({1'b0, gains.period});
      lim = $signed({1'b0, gains.int_limit});
      acc = integ_state;
      acc = acc + ((err * dt) >>> FRAC_BITS_DEF);
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      k = $signed(gains.kp);
      p = (k * err) >>> FRAC_BITS_DEF;
      k = $signed(gains.ki);
      i = (k * acc) >>> FRAC_BITS_DEF;
      k = $signed(gains.kd);
      d = last_err;
      d = (k * (err - d)) >>> FRAC_BITS_DEF;
      sum = p + i + d;
      lo  = $signed(gains.out_min);
      hi  = $signed(gains.out_max);
      if (sum > hi) sum = hi;
      else if (sum < lo) sum = lo;
      integ_state = acc[VAL_W-1:0];
      last_err    = err[VAL_W-1:0];
      return sum[VAL_W-1:0];
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (!pace || r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 4) return VMAX;
      if (r < 8) return VMIN;
      if (r < 11) return '0;
      if (r < 14) return ($urandom_range(1)) ? 32'sd1 : -32'sd1;
      if (r < 55) return int'($urandom_range(1 << 24)) - (1 << 23);
      return $urandom();
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_gain();
      int r;
      r = $urandom_range(99);
      if (r < 4) return VMAX;
      if (r < 8) return VMIN;
      if (r < 12) return '0;
      if (r < 65) return int'($urandom_range(1 << 19)) - (1 << 18);
      return $urandom();
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_unsigned();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return PMAX;
      if (r < 75) return PERIOD_W'($urandom_range(1 << 22, 1));
      return PERIOD_W'($urandom());
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      logic signed [VAL_W-1:0] a, b;
      int r;
      s.kp        = pick_gain();
      s.ki        = pick_gain();
      s.kd        = pick_gain();
      s.period    = pick_unsigned();
      s.int_limit = pick_unsigned();
      a = pick_value();
      b = pick_value();
      r = $urandom_range(99);
      if (r < 15) begin
         s.out_min = VMIN;
         s.out_max = VMAX;
      end else if (r < 25) begin
         // crossed limits
         s.out_min = (a > b) ? a : b;
         s.out_max = (a > b) ? b : a;
      end else begin
         s.out_min = (a < b) ? a : b;
         s.out_max = (a < b) ? b : a;
      end
      return s;
   endfunction

   // every register in index order, then a write to the unused index
   task automatic load_settings(input cfg_type s);
      logic [VAL_W-1:0] data [NUM_CSR];
      data[CSR_KP]        = s.kp;
      data[CSR_KI]        = s.ki;
      data[CSR_KD]        = s.kd;
      data[CSR_PERIOD]    = {1'($urandom_range(1)), s.period};
      data[CSR_OUT_MIN]   = s.out_min;
      data[CSR_OUT_MAX]   = s.out_max;
      data[CSR_INT_LIMIT] = {1'($urandom_range(1)), s.int_limit};
      for (int k = 0; k < NUM_CSR; k++) begin
         csr_write_en <= 1'b1;
         csr_index    <= csr_idx_type'(k);
         csr_wdata    <= data[k];
         @(posedge clock);
      end
      csr_index <= CSR_UNUSED;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_write_en <= 1'b0;
      gains = s;
   endtask

   task automatic send_request(input logic kind, input logic signed [VAL_W-1:0] sp,
                               input logic signed [VAL_W-1:0] ms);
      int gap;
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_setpoint <= sp;
      req_measured <= ms;
      do @(posedge clock); while (req_stall);
      if (kind == REQ_CLEAR) begin
         integ_state = '0;
         last_err    = '0;
      end else begin
         drive_q.push_back(pid_step(sp, ms));
      end
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain responses; clear requests leave no response, so settle afterwards
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_error_saturation();
      send_request(REQ_COMPUTE, '0, '0);
      send_request(REQ_COMPUTE, VMAX, VMIN);
      send_request(REQ_COMPUTE, VMIN, VMAX);
      send_request(REQ_COMPUTE, VMAX, VMAX);
      send_request(REQ_COMPUTE, VMIN, 32'sd1);
      send_request(REQ_COMPUTE, 32'sd5 * ONE, -32'sd3 * ONE);
   endtask

   task automatic test_extreme_gains();
      cfg_type s;
      wait_idle();
      s = '{kp: VMIN, ki: VMAX, kd: VMIN, period: PMAX,
            out_min: VMIN, out_max: VMAX, int_limit: PMAX};
      load_settings(s);
      send_request(REQ_COMPUTE, VMAX, VMIN);
      send_request(REQ_COMPUTE, VMIN, VMAX);
      send_request(REQ_COMPUTE, VMAX, VMIN);
      send_request(REQ_COMPUTE, 32'sd1, '0);
   endtask

   task automatic test_clear();
      cfg_type s;
      wait_idle();
      s = '{kp: ONE, ki: ONE, kd: 32'sd3 * ONE, period: 31'd65536,
            out_min: VMIN, out_max: VMAX, int_limit: 31'd1000 * 31'd65536};
      load_settings(s);
      send_request(REQ_COMPUTE, 32'sd20 * ONE, '0);
      send_request(REQ_CLEAR, $urandom(), $urandom());
      send_request(REQ_COMPUTE, 32'sd20 * ONE, '0);
      send_request(REQ_CLEAR, '0, '0);
      send_request(REQ_CLEAR, VMAX, VMIN);
      send_request(REQ_COMPUTE, -32'sd7 * ONE, '0);
   endtask

   task automatic test_zero_period();
      cfg_type s;
      wait_idle();
      s = '{kp: '0, ki: ONE, kd: '0, period: '0,
            out_min: VMIN, out_max: VMAX, int_limit: 31'd50 * 31'd65536};
      load_settings(s);
      send_request(REQ_COMPUTE, VMAX, '0);
      send_request(REQ_COMPUTE, VMIN, '0);
   endtask

   task automatic test_crossed_limits();
      cfg_type s;
      wait_idle();
      s = '{kp: ONE, ki: ONE, kd: '0, period: 31'd65536,
            out_min: 32'sd10 * ONE, out_max: -32'sd10 * ONE, int_limit: '0};
      load_settings(s);
      send_request(REQ_COMPUTE, 32'sd50 * ONE, '0);
      send_request(REQ_COMPUTE, -32'sd50 * ONE, '0);
      send_request(REQ_COMPUTE, '0, '0);
   endtask

   // mostly tracking runs: measured hovers around a held setpoint
   task automatic test_random_phases();
      logic signed [VAL_W-1:0] target, offset;
      int r;
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         load_settings(random_settings());
         pace   = (ph % 3) != 2;
         target = pick_value();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 5) begin
               send_request(REQ_CLEAR, $urandom(), $urandom());
            end else if (r < 25) begin
               send_request(REQ_COMPUTE, pick_value(), pick_value());
            end else begin
               if (r < 30) target = pick_value();
               offset = int'($urandom_range(1 << 20)) - (1 << 19);
               send_request(REQ_COMPUTE, target, target + offset);
            end
         end
      end
      pace = 1'b0;
   endtask

   initial begin : stall_driver
      int n;
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_q.size() == 0) begin
            $display("%0t unexpected response: expected none, got drive %0d", $time, rsp_drive);
            mismatches++;
         end else if (rsp_drive !== drive_q[0]) begin
            $display("%0t drive mismatch: expected %0d, got %0d", $time, drive_q[0],
                     rsp_drive);
            mismatches++;
            void'(drive_q.pop_front());
         end else begin
            void'(drive_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t timeout: nothing accepted for %0d cycles", $time, quiet);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      gains = '{kp: KP_RST, ki: KI_RST, kd: KD_RST, period: PERIOD_RST,
                out_min: OUT_MIN_RST, out_max: OUT_MAX_RST, int_limit: INT_LIMIT_RST};
      integ_state = '0;
      last_err    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_error_saturation();
      test_extreme_gains();
      test_clear();
      test_zero_period();
      test_crossed_limits();
      test_random_phases();
      wait_idle();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
hdl/pidaw_pkg.sv
hdl/pidaw_sequencer.sv
hdl/pidaw_datapath.sv
hdl/pid_controller_anti_windup.sv
bench/testbench.sv
